/* hw/rtl/pn3d_pkg.sv */
// Shared types, constants and arithmetic helpers of the 3D gradient noise block.
package pn3d_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int OUT_FRAC_BITS   = 15;
  localparam int IQ              = 24;  // internal fraction bits
  localparam int PERM_DEPTH      = 256;
  localparam int PERM_AW         = $clog2(PERM_DEPTH);
  localparam int IN_W            = 112;
  localparam int OUT_W           = 16;

  typedef logic signed [31:0] q_t;

  localparam q_t ONE_Q     = q_t'(1) <<< IQ;
  localparam q_t FADE_A    = q_t'(15) <<< IQ;
  localparam q_t FADE_B    = q_t'(10) <<< IQ;
  localparam q_t SCALE_Q   = q_t'(16273900);

  // output conversion: round half up when dropping bits, plain shift when adding
  localparam int    OUT_SH  = (OUT_FRAC_BITS >= IQ) ? 0 : IQ - OUT_FRAC_BITS;
  localparam int    OUT_UP  = (OUT_FRAC_BITS >= IQ) ? OUT_FRAC_BITS - IQ : 0;
  localparam longint OUT_RND = (longint'(1) << OUT_SH) >> 1;

  typedef struct packed {
    logic [7:0] entry_value;
    logic [7:0] entry_index;
    logic [31:0] coord_z;
    logic [31:0] coord_y;
    logic [31:0] coord_x;
  } in_data_t;

  typedef enum logic {
    OP_EVAL  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  localparam logic [7:0] DEFAULT_PERM [PERM_DEPTH] = '{
    8'd63, 8'd9, 8'd212, 8'd205, 8'd31, 8'd128, 8'd72, 8'd59, 8'd137, 8'd203, 8'd195, 8'd170,
    8'd181, 8'd115, 8'd165, 8'd40, 8'd116, 8'd139, 8'd175, 8'd225, 8'd132, 8'd99, 8'd222, 8'd2,
    8'd41, 8'd15, 8'd197, 8'd93, 8'd169, 8'd90, 8'd228, 8'd43, 8'd221, 8'd38, 8'd206, 8'd204,
    8'd73, 8'd17, 8'd97, 8'd10, 8'd96, 8'd47, 8'd32, 8'd138, 8'd136, 8'd30, 8'd219,
    8'd78, 8'd224, 8'd13, 8'd193, 8'd88, 8'd134, 8'd211, 8'd7, 8'd112, 8'd176, 8'd19, 8'd106,
    8'd83, 8'd75, 8'd217, 8'd85, 8'd0, 8'd98, 8'd140, 8'd229, 8'd80, 8'd118, 8'd151, 8'd117,
    8'd251, 8'd103, 8'd242, 8'd81, 8'd238, 8'd172, 8'd82, 8'd110, 8'd4, 8'd227, 8'd77, 8'd243,
    8'd46, 8'd12, 8'd189, 8'd34, 8'd188, 8'd200, 8'd161, 8'd68, 8'd76, 8'd171, 8'd194,
    8'd57, 8'd48, 8'd247, 8'd233, 8'd51, 8'd105, 8'd5, 8'd23, 8'd42, 8'd50, 8'd216, 8'd45,
    8'd239, 8'd148, 8'd249, 8'd84, 8'd70, 8'd125, 8'd108, 8'd241, 8'd62, 8'd66, 8'd64, 8'd240,
    8'd173, 8'd185, 8'd250, 8'd49, 8'd6, 8'd37, 8'd26, 8'd21, 8'd244, 8'd60, 8'd223, 8'd255,
    8'd16, 8'd145, 8'd27, 8'd109, 8'd58, 8'd102, 8'd142, 8'd253, 8'd120, 8'd149, 8'd160,
    8'd124, 8'd156, 8'd79, 8'd186, 8'd135, 8'd127, 8'd14, 8'd121, 8'd22, 8'd65, 8'd54, 8'd153,
    8'd91, 8'd213, 8'd174, 8'd24, 8'd252, 8'd131, 8'd192, 8'd190, 8'd202, 8'd208, 8'd35, 8'd94,
    8'd231, 8'd56, 8'd95, 8'd183, 8'd163, 8'd111, 8'd147, 8'd25, 8'd67, 8'd36, 8'd92, 8'd236,
    8'd71, 8'd166, 8'd1, 8'd187, 8'd100, 8'd130, 8'd143, 8'd237, 8'd178, 8'd158,
    8'd104, 8'd184, 8'd159, 8'd177, 8'd52, 8'd214, 8'd230, 8'd119, 8'd87, 8'd114, 8'd201, 8'd179,
    8'd198, 8'd3, 8'd248, 8'd182, 8'd39, 8'd11, 8'd152, 8'd196, 8'd113, 8'd20, 8'd232, 8'd69,
    8'd141, 8'd207, 8'd234, 8'd53, 8'd86, 8'd180, 8'd226, 8'd74, 8'd150, 8'd218, 8'd29, 8'd133,
    8'd8, 8'd44, 8'd123, 8'd28, 8'd146, 8'd89, 8'd101, 8'd154, 8'd220, 8'd126,
    8'd155, 8'd122, 8'd210, 8'd168, 8'd254, 8'd162, 8'd129, 8'd33, 8'd18, 8'd209, 8'd61, 8'd191,
    8'd199, 8'd157, 8'd245, 8'd55, 8'd164, 8'd167, 8'd215, 8'd246, 8'd144, 8'd107, 8'd235
  };

  // Q24 product, rounded by adding half an LSB and flooring
  function automatic q_t qmul(q_t a, q_t b);
    logic signed [63:0] p;
    p = a * b;
    p = p + (64'sd1 <<< (IQ - 1));
    return q_t'(p >>> IQ);
  endfunction

  function automatic q_t grad(logic [3:0] h, q_t x, q_t y, q_t z);
    q_t r;
    unique case (h)
      4'd0:    r = x + z;
      4'd1:    r = x + y;
      4'd2:    r = y + z;
      4'd3:    r = y - x;
      4'd4:    r = z - x;
      4'd5:    r = -x - y;
      4'd6:    r = z - y;
      4'd7:    r = x - y;
      4'd8:    r = x - z;
      4'd9:    r = y - z;
      4'd10:   r = -x - z;
      4'd11:   r = -y - z;
      4'd12:   r = x + y;
      4'd13:   r = y - x;
      4'd14:   r = z - y;
      default: r = -y - z;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/perlin_noise_3d.sv */
// Top level of the 3D gradient noise pipeline.
//
//  channel  | dir | tdata                                       | tuser
//  s_axis   | in  | coord_x, coord_y, coord_z, entry_index, val | opcode
//  m_axis   | out | noise_value                                 | -
//
// One item per cycle while the output is not stalled.
// Table lookups run in three levels (stages 1-3), fade in stages 1-4, the
// trilinear blend in stages 5-10, scale and output conversion in 11-12.
// A table write lands in each lookup level as it passes it, so order is kept.
// After reset the table reads as the default permutation; no clearing pass.
// A stalled output fills the empty stages first; every transfer is kept.
module perlin_noise_3d (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // coord_x, coord_y, coord_z, entry_index, entry_value
  input  logic [pn3d_pkg::IN_W-1:0]  s_axis_tdata,
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [pn3d_pkg::OUT_W-1:0] m_axis_tdata    // noise_value
);
  import pn3d_pkg::*;

  localparam int NS = 12;

  in_data_t in_d;
  logic     accept;
  logic [NS+1:1] en;
  logic [NS:1]   v_q;

  logic       op1_q, op2_q, op3_q;
  logic [7:0] idx1_q, idx2_q, val1_q, val2_q;
  logic [7:0] yi1_q, zi1_q, zi2_q;
  q_t crd1_q [3];
  q_t crd2_q [3];
  q_t crd3_q [3];
  q_t t2_q [3];
  q_t inner2_q [3];
  q_t t3_q [3];
  q_t inner3_q [3];
  q_t fd_q [4:9][3];
  q_t g_q [8];
  q_t a5_q [4];
  q_t d5_q [4];
  q_t l6_q [4];
  q_t a7_q [2];
  q_t d7_q [2];
  q_t n8_q [2];
  q_t a9_q, d9_q, n10_q, s11_q;
  logic [OUT_W-1:0] out12_q;

  logic [7:0] p1 [2];
  logic [7:0] p2 [4];
  logic [7:0] p3 [8];
  logic [7:0] xi_in, a_addr, b_addr;
  logic [7:0] h_addr [4];
  logic signed [47:0] r;
  logic [OUT_W-1:0] out_d;

  assign in_d   = in_data_t'(s_axis_tdata);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign xi_in  = in_d.coord_x[COORD_FRAC_BITS +: 8];

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[NS+1] = m_axis_tready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = v_q[NS];
  assign m_axis_tdata  = out12_q;

  function automatic q_t frac_q(logic [31:0] c);
    return q_t'(32'(c[COORD_FRAC_BITS-1:0]) << (IQ - COORD_FRAC_BITS));
  endfunction

  // ---- permutation lookups, three levels ----
  pn3d_perm u_perm_l1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (accept && (op_e'(s_axis_tuser) == OP_WRITE)),
    .waddr_i  (in_d.entry_index),
    .wdata_i  (in_d.entry_value),
    .re_i     (en[1]),
    .raddr0_i (xi_in),
    .raddr1_i (8'(xi_in + 8'd1)),
    .rdata0_o (p1[0]),
    .rdata1_o (p1[1])
  );

  assign a_addr = 8'(p1[0] + yi1_q);
  assign b_addr = 8'(p1[1] + yi1_q);

  for (genvar i = 0; i < 2; i++) begin : g_l2
    pn3d_perm u_perm_l2 (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .we_i     (en[2] && v_q[1] && (op_e'(op1_q) == OP_WRITE)),
      .waddr_i  (idx1_q),
      .wdata_i  (val1_q),
      .re_i     (en[2]),
      .raddr0_i ((i == 0) ? a_addr : b_addr),
      .raddr1_i (8'(((i == 0) ? a_addr : b_addr) + 8'd1)),
      .rdata0_o (p2[2*i]),
      .rdata1_o (p2[2*i+1])
    );
  end

  // p2: pt(a), pt(a+1), pt(b), pt(b+1); level 3 reads aa, ba, ab, bb and their +1
  assign h_addr[0] = 8'(p2[0] + zi2_q);  // aa
  assign h_addr[1] = 8'(p2[2] + zi2_q);  // ba
  assign h_addr[2] = 8'(p2[1] + zi2_q);  // ab
  assign h_addr[3] = 8'(p2[3] + zi2_q);  // bb

  for (genvar i = 0; i < 4; i++) begin : g_l3
    pn3d_perm u_perm_l3 (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .we_i     (en[3] && v_q[2] && (op_e'(op2_q) == OP_WRITE)),
      .waddr_i  (idx2_q),
      .wdata_i  (val2_q),
      .re_i     (en[3]),
      .raddr0_i (h_addr[i]),
      .raddr1_i (8'(h_addr[i] + 8'd1)),
      .rdata0_o (p3[i]),
      .rdata1_o (p3[4+i])
    );
  end

  // ---- output conversion ----
  always_comb begin
    r = ((48'(s11_q) + 48'(OUT_RND)) >>> OUT_SH) <<< OUT_UP;
    if (r > (48'sd1 <<< OUT_FRAC_BITS)) begin
      r = 48'sd1 <<< OUT_FRAC_BITS;
    end
    if (r < -(48'sd1 <<< OUT_FRAC_BITS)) begin
      r = -(48'sd1 <<< OUT_FRAC_BITS);
    end
    if (r > 48'sd32767) begin
      r = 48'sd32767;
    end
    if (r < -48'sd32768) begin
      r = -48'sd32768;
    end
    out_d = r[OUT_W-1:0];
  end

  // ---- valid bits ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= s_axis_tvalid;
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
      // writes are done after level 3
      if (en[4]) v_q[4] <= v_q[3] && (op_e'(op3_q) == OP_EVAL);
      for (int k = 5; k <= NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---- payload ----
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      op1_q     <= s_axis_tuser;
      idx1_q    <= in_d.entry_index;
      val1_q    <= in_d.entry_value;
      yi1_q     <= in_d.coord_y[COORD_FRAC_BITS +: 8];
      zi1_q     <= in_d.coord_z[COORD_FRAC_BITS +: 8];
      crd1_q[0] <= frac_q(in_d.coord_x);
      crd1_q[1] <= frac_q(in_d.coord_y);
      crd1_q[2] <= frac_q(in_d.coord_z);
    end
    if (en[2]) begin
      op2_q  <= op1_q;
      idx2_q <= idx1_q;
      val2_q <= val1_q;
      zi2_q  <= zi1_q;
      for (int i = 0; i < 3; i++) begin
        crd2_q[i]   <= crd1_q[i];
        t2_q[i]     <= qmul(crd1_q[i], crd1_q[i]);
        inner2_q[i] <= qmul(crd1_q[i], (crd1_q[i] <<< 2) + (crd1_q[i] <<< 1) - FADE_A)
                       + FADE_B;
      end
    end
    if (en[3]) begin
      op3_q <= op2_q;
      for (int i = 0; i < 3; i++) begin
        crd3_q[i]   <= crd2_q[i];
        t3_q[i]     <= qmul(t2_q[i], crd2_q[i]);
        inner3_q[i] <= inner2_q[i];
      end
    end
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        fd_q[4][i] <= qmul(t3_q[i], inner3_q[i]);
      end
      g_q[0] <= grad(p3[0][3:0], crd3_q[0], crd3_q[1], crd3_q[2]);
      g_q[1] <= grad(p3[1][3:0], crd3_q[0] - ONE_Q, crd3_q[1], crd3_q[2]);
      g_q[2] <= grad(p3[2][3:0], crd3_q[0], crd3_q[1] - ONE_Q, crd3_q[2]);
      g_q[3] <= grad(p3[3][3:0], crd3_q[0] - ONE_Q, crd3_q[1] - ONE_Q, crd3_q[2]);
      g_q[4] <= grad(p3[4][3:0], crd3_q[0], crd3_q[1], crd3_q[2] - ONE_Q);
      g_q[5] <= grad(p3[5][3:0], crd3_q[0] - ONE_Q, crd3_q[1], crd3_q[2] - ONE_Q);
      g_q[6] <= grad(p3[6][3:0], crd3_q[0], crd3_q[1] - ONE_Q, crd3_q[2] - ONE_Q);
      g_q[7] <= grad(p3[7][3:0], crd3_q[0] - ONE_Q, crd3_q[1] - ONE_Q,
                     crd3_q[2] - ONE_Q);
    end
    for (int k = 5; k <= 9; k++) begin
      if (en[k]) begin
        fd_q[k] <= fd_q[k-1];
      end
    end
    // blend along x
    if (en[5]) begin
      for (int i = 0; i < 4; i++) begin
        a5_q[i] <= g_q[2*i];
        d5_q[i] <= g_q[2*i+1] - g_q[2*i];
      end
    end
    if (en[6]) begin
      for (int i = 0; i < 4; i++) begin
        l6_q[i] <= a5_q[i] + qmul(fd_q[5][0], d5_q[i]);
      end
    end
    // along y
    if (en[7]) begin
      for (int j = 0; j < 2; j++) begin
        a7_q[j] <= l6_q[2*j];
        d7_q[j] <= l6_q[2*j+1] - l6_q[2*j];
      end
    end
    if (en[8]) begin
      for (int j = 0; j < 2; j++) begin
        n8_q[j] <= a7_q[j] + qmul(fd_q[7][1], d7_q[j]);
      end
    end
    // along z
    if (en[9]) begin
      a9_q <= n8_q[0];
      d9_q <= n8_q[1] - n8_q[0];
    end
    if (en[10]) n10_q <= a9_q + qmul(fd_q[9][2], d9_q);
    if (en[11]) s11_q <= qmul(n10_q, SCALE_Q);
    if (en[12]) out12_q <= out_d;
  end

  // ---- assertions ----
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !m_axis_tready |-> !s_axis_tready)
    else $error("accepting while the pipeline is full and stalled");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[1] |-> s_axis_tready)
    else $error("first stage empty but not ready");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS] && !m_axis_tready |=> v_q[NS])
    else $error("stalled result dropped");

  a_fade_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (fd_q[4][0] >= 0) && (fd_q[4][1] >= 0) && (fd_q[4][2] >= 0))
    else $error("fade weight negative");

endmodule

/* hw/rtl/pn3d_ram.sv */
// Generic RAM: one write port, two registered read ports.
module pn3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q, rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

/* hw/rtl/pn3d_perm.sv */
// One copy of the permutation table: RAM plus per-entry valid bits over the default.
module pn3d_perm (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [pn3d_pkg::PERM_AW-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [pn3d_pkg::PERM_AW-1:0] raddr0_i,
  input  logic [pn3d_pkg::PERM_AW-1:0] raddr1_i,
  output logic [7:0]               rdata0_o,
  output logic [7:0]               rdata1_o
);
  import pn3d_pkg::*;

  logic [PERM_DEPTH-1:0] valid_q;
  logic                  vld0_q, vld1_q;
  logic [7:0]            dflt0_q, dflt1_q;
  logic [7:0]            ram0, ram1;

  pn3d_ram #(
    .WIDTH(8),
    .DEPTH(PERM_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we_i),
    .waddr_i  (waddr_i),
    .wdata_i  (wdata_i),
    .re_i     (re_i),
    .raddr0_i (raddr0_i),
    .raddr1_i (raddr1_i),
    .rdata0_o (ram0),
    .rdata1_o (ram1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      vld0_q  <= valid_q[raddr0_i];
      vld1_q  <= valid_q[raddr1_i];
      dflt0_q <= DEFAULT_PERM[raddr0_i];
      dflt1_q <= DEFAULT_PERM[raddr1_i];
    end
  end

  assign rdata0_o = vld0_q ? ram0 : dflt0_q;
  assign rdata1_o = vld1_q ? ram1 : dflt1_q;

endmodule
